>>> sv/rrds_pkg.sv
// ----------------------------------------------------------------------------
// rrds_pkg
// Shared types and constants for the region deviation block.
// ----------------------------------------------------------------------------
package rrds_pkg;

  localparam int unsigned DevW  = 16;
  localparam int unsigned CntW  = 17;
  localparam int unsigned ThrW  = 16;
  localparam logic [7:0]  Scale = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [DevW-1:0] dev_red;
    logic [DevW-1:0] dev_green;
    logic [DevW-1:0] dev_blue;
    logic [DevW-1:0] dev_combined;
    logic            subdivide;
    logic [CntW-1:0] region_pixels;
    logic            overflow;
  } result_t;

  // Start/finish strobes between sequencer and root/divide unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;

endpackage

>>> sv/rrds_if.sv
// ----------------------------------------------------------------------------
// rrds_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface rrds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rrds_accum.sv
// ----------------------------------------------------------------------------
// rrds_accum
// Per-region pixel count, channel sums and sums of squares.
// ----------------------------------------------------------------------------
module rrds_accum
  import rrds_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned NW         = 25,
  parameter int unsigned S1W        = 33,
  parameter int unsigned S2W        = 41
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                add,
  input  logic                clear,
  input  logic [7:0]          pix [3],
  output logic [NW-1:0]       count,
  output logic [S1W-1:0]      sum1 [3],
  output logic [S2W-1:0]      sum2 [3],
  output logic                ovf
);
  localparam logic [NW-1:0] MaxN = NW'(MAX_PIXELS);
  logic full;
  assign full = (count == MaxN);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
      ovf   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum1[c] <= '0;
        sum2[c] <= '0;
      end
    end else if (add) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + 1'b1;
        for (int c = 0; c < 3; c++) begin
          sum1[c] <= sum1[c] + S1W'(pix[c]);
          sum2[c] <= sum2[c] + S2W'(16'(pix[c]) * 16'(pix[c]));
        end
      end
    end
  end
endmodule

>>> sv/rrds_rootdiv.sv
// ----------------------------------------------------------------------------
// rrds_rootdiv
// Bit-serial square root of d*4^F, then restoring divide by 255*n.
// ----------------------------------------------------------------------------
module rrds_rootdiv
  import rrds_pkg::*;
#(
  parameter int unsigned DW = 82,
  parameter int unsigned NW = 25,
  parameter int unsigned FB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  unit_ctl_t     ctl_in,
  input  logic [DW-1:0] d,
  input  logic [NW-1:0] n,
  output unit_ctl_t     ctl_out,
  output logic [DW-1:0] quo
);
  localparam int unsigned TW = DW + 2*FB + 2;
  localparam int unsigned QW = TW/2 + 1;
  localparam int unsigned DivW = NW + 8;
  localparam int unsigned CW = $clog2(TW + 2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROOT = 3'b010,
    S_DIV  = 3'b100
  } st_t;

  st_t st;
  logic [TW-1:0]  rad;
  logic [QW+1:0]  rem;
  logic [QW-1:0]  root;
  logic [DivW-1:0] divisor;
  logic [QW:0]    drem;
  logic [CW-1:0]  cnt;
  logic [QW+1:0]  trial;
  logic [QW:0]    dsh;

  // Classic digit-by-digit root: two radicand bits per step
  assign trial = {rem[QW-1:0], rad[TW-1 -: 2]} - {root, 2'b01};
  assign dsh   = {drem[QW-1:0], root[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ctl_out <= '0;
    end else begin
      ctl_out.done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (ctl_in.start) begin
            rad  <= TW'(d) << (2*FB);
            rem  <= '0;
            root <= '0;
            divisor <= DivW'(n) * DivW'(Scale);
            cnt  <= CW'(TW/2);
            st   <= S_ROOT;
            ctl_out.busy <= 1'b1;
          end
        end
        S_ROOT: begin
          rad <= rad << 2;
          if (!trial[QW+1]) begin
            rem  <= trial;
            root <= {root[QW-2:0], 1'b1};
          end else begin
            rem  <= {rem[QW-1:0], rad[TW-1 -: 2]};
            root <= {root[QW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            drem <= '0;
            cnt  <= CW'(QW);
            st   <= S_DIV;
          end
        end
        S_DIV: begin
          // root register doubles as dividend/quotient shifter
          if (dsh >= (QW+1)'(divisor)) begin
            drem <= dsh - (QW+1)'(divisor);
            root <= {root[QW-2:0], 1'b1};
          end else begin
            drem <= dsh;
            root <= {root[QW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            st <= S_IDLE;
            ctl_out.busy <= 1'b0;
            ctl_out.done <= 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
  assign quo = DW'(root);
endmodule

>>> sv/rgb_region_deviation_split.sv
// ----------------------------------------------------------------------------
// rgb_region_deviation_split
// Per-region RGB standard deviation with subdivide decision.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while no result is pending. On a beat marked
// last the block stops taking pixels and runs each channel in turn through one
// shared bit-serial root/divide unit. Per channel: the n*S2 and S1^2 products are
// registered, a start strobe is issued, the root steps run (two radicand bits
// each), then the divide steps (one quotient bit each), and the unit signals done.
// The result is held until taken; the next region's pixels are accepted once it
// has been delivered.
module rgb_region_deviation_split
  import rrds_pkg::*;
#(
  parameter int unsigned MAX_PIXELS    = 65536,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  rrds_stream_if.sink            pixel_in,
  rrds_stream_if.source          result_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ThrW-1:0]        cfg_data
);
  localparam int unsigned NW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned S1W = NW + 8;
  localparam int unsigned S2W = NW + 16;
  localparam int unsigned DW  = NW + S2W;
  localparam logic [DevW-1:0] DevMax = '1;
  // ceil(2^19/3): exact floor divide by 3 for sums below 2^19
  localparam logic [18:0] ThirdRecip = 19'd174763;

  typedef enum logic [4:0] {
    S_ACC  = 5'b00001,
    S_PREP = 5'b00010,
    S_GO   = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } seq_t;

  seq_t st;
  logic [ThrW-1:0] split_threshold;
  logic [7:0] pix [3];
  logic [NW-1:0] count;
  logic [S1W-1:0] sum1 [3];
  logic [S2W-1:0] sum2 [3];
  logic ovf, acc_add, acc_clear;
  logic [1:0] ch;
  logic [DW-1:0] d, quo;
  logic [DW-1:0] prod_a, prod_b;
  unit_ctl_t uc_in, uc_out;
  logic [DevW-1:0] dev [3];
  logic [DevW+1:0] dsum;
  logic [37:0] dprod;
  result_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) split_threshold <= '0;
    else if (cfg_valid) split_threshold <= cfg_data;
  end

  assign pix[0] = pixel_in.data.red;
  assign pix[1] = pixel_in.data.green;
  assign pix[2] = pixel_in.data.blue;
  assign pixel_in.ready = (st == S_ACC);
  assign acc_add = pixel_in.valid && pixel_in.ready;

  rrds_accum #(.MAX_PIXELS(MAX_PIXELS), .NW(NW), .S1W(S1W), .S2W(S2W)) u_acc (
    .clk, .rst, .add(acc_add), .clear(acc_clear), .pix,
    .count, .sum1, .sum2, .ovf
  );

  // Operands registered so each product stands alone before the subtract
  always_ff @(posedge clk) begin
    prod_a <= DW'(count) * DW'(sum2[ch]);
    prod_b <= DW'(sum1[ch]) * DW'(sum1[ch]);
  end
  assign d = prod_a - prod_b;

  rrds_rootdiv #(.DW(DW), .NW(NW), .FB(FRACTION_BITS)) u_rd (
    .clk, .rst, .ctl_in(uc_in), .d, .n(count), .ctl_out(uc_out), .quo
  );

  always_comb begin
    uc_in = '0;
    uc_in.start = (st == S_GO);
  end

  assign dsum  = (DevW+2)'(dev[0]) + (DevW+2)'(dev[1]) + (DevW+2)'(dev[2]);
  assign dprod = 38'(dsum) * 38'(ThirdRecip);
  assign acc_clear = (st == S_OUT) && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_ACC;
      ch <= '0;
    end else begin
      unique case (st)
        S_ACC: begin
          ch <= '0;
          if (acc_add && pixel_in.data.last_pixel) st <= S_PREP;
        end
        // products pick up the final sums and the current channel here
        S_PREP: st <= S_GO;
        S_GO: st <= S_WAIT;
        S_WAIT: begin
          if (uc_out.done) begin
            dev[ch] <= (quo > DW'(DevMax)) ? DevMax : quo[DevW-1:0];
            if (ch == 2'd2) begin
              st <= S_OUT;
            end else begin
              ch <= ch + 1'b1;
              st <= S_PREP;
            end
          end
        end
        S_OUT: if (result_out.ready) st <= S_ACC;
        default: st <= S_ACC;
      endcase
    end
  end

  always_comb begin
    res.dev_red      = dev[0];
    res.dev_green    = dev[1];
    res.dev_blue     = dev[2];
    res.dev_combined = dprod[19 +: DevW];
    res.subdivide    = res.dev_combined > split_threshold;
    res.region_pixels = (NW > CntW && count > NW'({CntW{1'b1}})) ? '1 : CntW'(count);
    res.overflow     = ovf;
  end
  assign result_out.valid = (st == S_OUT);
  assign result_out.data  = res;

  a_no_pix_busy: assert property (@(posedge clk) disable iff (rst)
    (st != S_ACC) |-> !pixel_in.ready) else $error("pixel taken while busy");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.ready) |=> (count == '0)) else $error("not cleared");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    uc_in.start |-> !uc_out.busy) else $error("unit restarted");
endmodule
